// ===== design/tfssf_pkg.sv =====
package tfssf_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int DIGIT_W     = $clog2(DIGIT_COUNT);
  localparam int GRID_W      = 4;
  localparam int SEG_W       = 8;
  localparam int VALUE_W     = 16;
  localparam int HALF_W      = VALUE_W / 2;
  localparam int BCD_W       = 16;
  localparam int BCD_DIGITS  = BCD_W / 4;
  localparam int RIGHT_BCD_W = 12;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIGIT_W-1:0] POS_L_THOU  = DIGIT_W'(0);
  localparam logic [DIGIT_W-1:0] POS_L_HUND  = DIGIT_W'(1);
  localparam logic [DIGIT_W-1:0] POS_L_TENS  = DIGIT_W'(2);
  localparam logic [DIGIT_W-1:0] POS_L_UNITS = DIGIT_W'(3);
  localparam logic [DIGIT_W-1:0] POS_LETTER  = DIGIT_W'(4);
  localparam logic [DIGIT_W-1:0] POS_R_HUND  = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] POS_R_TENS  = DIGIT_W'(6);
  localparam logic [DIGIT_W-1:0] POS_R_UNITS = DIGIT_W'(7);
  localparam logic [DIGIT_W-1:0] LAST_POS    = DIGIT_W'(DIGIT_COUNT - 1);

  localparam logic [SEG_W-1:0] SEG_LETTER_A = 8'h77;
  localparam logic [SEG_W-1:0] SEG_BLANK    = 8'h00;
  localparam logic [SEG_W-1:0] SEG_POINT    = 8'h80;

  localparam logic [VALUE_W-1:0] RIGHT_BLANK_LIMIT = 16'd100;

  typedef struct packed {
    logic [BCD_W-1:0]       left_bcd;
    logic [RIGHT_BCD_W-1:0] right_bcd;
    logic                   right_small;
  } digit_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // one shift-add-3 step, digits above the top one are dropped
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic din);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], din};
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== design/tfssf_front.sv =====
module tfssf_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [15:0]               left_value,
  input  logic [15:0]               right_value,
  input  tfssf_pkg::queue_status_t  q_status,
  output logic                      push,
  output tfssf_pkg::digit_set_t     push_data
);
  import tfssf_pkg::*;

  logic               s1_valid;
  logic [BCD_W-1:0]   s1_lbcd;
  logic [BCD_W-1:0]   s1_rbcd;
  logic [HALF_W-1:0]  s1_lrest;
  logic [HALF_W-1:0]  s1_rrest;
  logic               s1_small;

  logic               advance;
  logic               accept;
  logic [BCD_W-1:0]   lbcd_hi;
  logic [BCD_W-1:0]   rbcd_hi;
  logic [BCD_W-1:0]   lbcd_lo;
  logic [BCD_W-1:0]   rbcd_lo;

  assign advance  = !s1_valid || !q_status.full;
  assign in_stall = s1_valid && q_status.full;
  assign accept   = in_valid && !in_stall;

  // upper byte of each value
  always_comb begin
    lbcd_hi = '0;
    rbcd_hi = '0;
    for (int i = HALF_W - 1; i >= 0; i--) begin
      lbcd_hi = dabble_step(lbcd_hi, left_value[HALF_W + i]);
      rbcd_hi = dabble_step(rbcd_hi, right_value[HALF_W + i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lbcd  <= lbcd_hi;
      s1_rbcd  <= rbcd_hi;
      s1_lrest <= left_value[HALF_W-1:0];
      s1_rrest <= right_value[HALF_W-1:0];
      s1_small <= right_value < RIGHT_BLANK_LIMIT;
    end
  end

  // lower byte
  always_comb begin
    lbcd_lo = s1_lbcd;
    rbcd_lo = s1_rbcd;
    for (int i = HALF_W - 1; i >= 0; i--) begin
      lbcd_lo = dabble_step(lbcd_lo, s1_lrest[i]);
      rbcd_lo = dabble_step(rbcd_lo, s1_rrest[i]);
    end
  end

  assign push                  = s1_valid && !q_status.full;
  assign push_data.left_bcd    = lbcd_lo;
  assign push_data.right_bcd   = rbcd_lo[RIGHT_BCD_W-1:0];
  assign push_data.right_small = s1_small;

endmodule

// ===== design/tfssf_queue.sv =====
module tfssf_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  tfssf_pkg::digit_set_t     push_data,
  input  logic                      pop,
  output tfssf_pkg::digit_set_t     head,
  output tfssf_pkg::queue_status_t  status
);
  import tfssf_pkg::*;

  digit_set_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = count == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/tfssf_back.sv =====
module tfssf_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      point_enable,
  input  tfssf_pkg::digit_set_t     head,
  input  tfssf_pkg::queue_status_t  q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                grid_address,
  output logic [7:0]                segment_bits,
  output logic                      last_digit
);
  import tfssf_pkg::*;

  logic [DIGIT_W-1:0]  pos;
  logic                load;
  logic [SEG_W-1:0]    seg_next;

  assign load = !q_status.empty && (!out_valid || !out_stall);
  assign pop  = load && pos == LAST_POS;

  always_comb begin
    case (pos)
      POS_L_THOU:  seg_next = seg_of(head.left_bcd[15:12]);
      POS_L_HUND:  seg_next = seg_of(head.left_bcd[11:8]);
      POS_L_TENS:  seg_next = seg_of(head.left_bcd[7:4]);
      POS_L_UNITS: seg_next = seg_of(head.left_bcd[3:0]);
      POS_LETTER:  seg_next = SEG_LETTER_A;
      POS_R_HUND:  seg_next = head.right_small ? SEG_BLANK : seg_of(head.right_bcd[11:8]);
      POS_R_TENS:  seg_next = seg_of(head.right_bcd[7:4]) | (point_enable ? SEG_POINT : SEG_BLANK);
      POS_R_UNITS: seg_next = seg_of(head.right_bcd[3:0]);
      default:     seg_next = SEG_BLANK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= pos + 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grid_address <= GRID_W'({pos, 1'b0});
      segment_bits <= seg_next;
      last_digit   <= pos == LAST_POS;
    end
  end

endmodule

// ===== design/two_field_seven_segment_formatter.sv =====
// Two-field seven-segment formatter.
// Input channel: in_valid / in_stall with left_value and right_value; one
// transfer gives eight output transfers, digit 0 through digit 7.
// Output channel: out_valid / out_stall with grid_address (twice the digit
// index), segment_bits and last_digit, high on digit 7.
// Config: cfg_we writes cfg_wdata into the point enable bit, which puts the
// decimal point on digit 6; write it only while no transfer is in flight.
// Path: conversion register, then a queue entry, then the output register.
// Flow: the output stage sends one digit per cycle while out_stall is
// low; a two-entry queue of converted digits sits between the
// conversion pipeline and the output stage, so new input is taken while
// earlier items are still being sent.
// Reset: synchronous, clears all valids and the queue and sets point enable.
// When the receiver stalls the output holds its digit; the queue then fills
// and in_stall rises once the conversion stage also holds an item.
module two_field_seven_segment_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] left_value,
  input  logic [15:0] right_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  grid_address,
  output logic [7:0]  segment_bits,
  output logic        last_digit
);
  import tfssf_pkg::*;

  logic           point_enable;
  logic           push;
  logic           pop;
  digit_set_t     push_data;
  digit_set_t     head;
  queue_status_t  q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_enable <= 1'b1;
    end else if (cfg_we) begin
      point_enable <= cfg_wdata;
    end
  end

  tfssf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .left_value  (left_value),
    .right_value (right_value),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  tfssf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  tfssf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .point_enable (point_enable),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .grid_address (grid_address),
    .segment_bits (segment_bits),
    .last_digit   (last_digit)
  );

endmodule

// ===== design/tfssf_checker.sv =====
module tfssf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] grid_address,
  input logic [7:0] segment_bits,
  input logic       last_digit
);
  import tfssf_pkg::*;

  a_last_on_top_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_digit == (grid_address == 4'd14)))
    else $error("last_digit does not match digit 7");

  a_grid_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !grid_address[0])
    else $error("odd grid address");

  a_letter_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && grid_address == 4'd8 |-> segment_bits == SEG_LETTER_A)
    else $error("digit 4 is not the letter");

  a_digit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_digit |=>
      !out_valid || grid_address == $past(grid_address) + 4'd2)
    else $error("digit order broken");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(segment_bits)
      && $stable(grid_address))
    else $error("stalled transfer changed");

endmodule

bind two_field_seven_segment_formatter tfssf_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .grid_address (grid_address),
  .segment_bits (segment_bits),
  .last_digit   (last_digit)
);

// ===== tb/two_field_seven_segment_formatter_test.sv =====
module two_field_seven_segment_formatter_test;
  import tfssf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 40;
  localparam int DIRECTED_COUNT = 16;

  typedef struct {
    logic [3:0] grid;
    logic [7:0] seg;
    logic       last;
  } digit_result_t;

  class segment_scoreboard;
    digit_result_t pending_digits[$];
    bit point_on;
    int errors;

    function new();
      point_on = 1'b1;
      errors = 0;
    endfunction

    function logic [7:0] glyph(int unsigned d);
      logic [7:0] g;
      case (d)
        0: g = 8'h3F;
        1: g = 8'h06;
        2: g = 8'h5B;
        3: g = 8'h4F;
        4: g = 8'h66;
        5: g = 8'h6D;
        6: g = 8'h7D;
        7: g = 8'h07;
        8: g = 8'h7F;
        default: g = 8'h6F;
      endcase
      return g;
    endfunction

    function void note_input(logic [15:0] left_v, logic [15:0] right_v);
      digit_result_t r;
      int unsigned lv;
      int unsigned rv;
      lv = 32'(left_v);
      rv = 32'(right_v);
      for (int j = 0; j < DIGIT_COUNT; j++) begin
        case (j)
          0: r.seg = glyph((lv / 1000) % 10);
          1: r.seg = glyph((lv / 100) % 10);
          2: r.seg = glyph((lv / 10) % 10);
          3: r.seg = glyph(lv % 10);
          4: r.seg = SEG_LETTER_A;
          5: r.seg = (right_v < RIGHT_BLANK_LIMIT) ? SEG_BLANK : glyph((rv / 100) % 10);
          6: r.seg = glyph((rv / 10) % 10);
          default: r.seg = glyph(rv % 10);
        endcase
        if (point_on && j == 6) begin
          r.seg = r.seg | SEG_POINT;
        end
        r.grid = 4'(2 * j);
        r.last = (j == DIGIT_COUNT - 1);
        pending_digits.push_back(r);
      end
    endfunction

    task report(string msg);
      if (errors < 30) begin
        $display("mismatch: %s", msg);
      end
      errors++;
    endtask

    task check_result(logic [3:0] grid, logic [7:0] seg, logic last);
      digit_result_t want;
      if (pending_digits.size() == 0) begin
        report($sformatf("digit transfer with none expected, grid %0d seg %h", grid, seg));
      end else begin
        want = pending_digits.pop_front();
        if (grid !== want.grid) begin
          report($sformatf("grid_address %h, expected %h", grid, want.grid));
        end
        if (seg !== want.seg) begin
          report($sformatf("segment_bits %h, expected %h (grid %0d)", seg, want.seg, want.grid));
        end
        if (last !== want.last) begin
          report($sformatf("last_digit %b, expected %b (grid %0d)", last, want.last, want.grid));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] left_value = 16'd0;
  logic [15:0] right_value = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  grid_address;
  logic [7:0]  segment_bits;
  logic        last_digit;

  int idle_pct = 0;
  int stall_pct = 0;
  int unsigned cycle_count = 0;
  segment_scoreboard display_sb = new();

  logic [15:0] directed_left[DIRECTED_COUNT] = '{
    16'd0, 16'd65535, 16'd9999, 16'd1234, 16'd10000, 16'd5678, 16'd0, 16'd0,
    16'd4321, 16'd65535, 16'hAAAA, 16'h5555, 16'd999, 16'd1000, 16'd7, 16'd60000
  };
  logic [15:0] directed_right[DIRECTED_COUNT] = '{
    16'd0, 16'd65535, 16'd999, 16'd99, 16'd100, 16'd0, 16'd9, 16'd10,
    16'd65535, 16'd0, 16'h5555, 16'hAAAA, 16'd1000, 16'd1099, 16'd101, 16'd50
  };

  two_field_seven_segment_formatter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_value   (left_value),
    .right_value  (right_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .grid_address (grid_address),
    .segment_bits (segment_bits),
    .last_digit   (last_digit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // note each transfer on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        display_sb.note_input(left_value, right_value);
      end
      if (out_valid && !out_stall) begin
        display_sb.check_result(grid_address, segment_bits, last_digit);
      end
    end
  end

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(4))
      0: v = 16'($urandom_range(0, 99));
      1: v = 16'($urandom_range(90, 1100));
      2: v = 16'($urandom_range(9990, 10010));
      3: v = 16'($urandom_range(60000, 65535));
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task send_values(logic [15:0] lv, logic [15:0] rv);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 12) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_value <= lv;
    right_value <= rv;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (display_sb.pending_digits.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task write_point(bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    display_sb.point_on = v;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of the point enable first, then both settings
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (i == 6) begin
        wait_idle();
        write_point(1'b0);
      end else if (i == 11) begin
        wait_idle();
        write_point(1'b1);
      end
      send_values(directed_left[i], directed_right[i]);
    end
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 52;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 52;
        end
        default: begin
          idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      write_point(phase[0]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i == RANDOM_PER_PHASE / 2) begin
          wait_idle();
        end
        send_values(pick_value(), pick_value());
      end
      wait_idle();
    end

    idle_pct = 0;
    stall_pct = 0;
    wait_idle();
    repeat (8) @(posedge clk);
    if (display_sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tfssf_pkg.sv
design/tfssf_front.sv
design/tfssf_queue.sv
design/tfssf_back.sv
design/two_field_seven_segment_formatter.sv
design/tfssf_checker.sv
tb/two_field_seven_segment_formatter_test.sv
